### rtl/pgg_pkg.sv
`default_nettype none
package pgg_pkg;
  localparam int UNIFORM_BITS_DEF = 16;
  localparam int IN_W = 16;
  localparam int MAG_W = 32;
  localparam int SQ_W = 62;
  localparam int LOG_FRAC_W = 24;
  localparam int SAMPLE_W = 16;
  localparam logic [30:0] TWO_LN2_Q30 = 31'd1488522236;
  localparam int WQ_DEPTH = 4;
  localparam int RQ_DEPTH = 2;
  localparam int WQ_LVL_W = $clog2(WQ_DEPTH + 1);

  typedef struct packed {
    logic [SQ_W-1:0]  sq;
    logic [MAG_W-1:0] mag_a;
    logic [MAG_W-1:0] mag_b;
    logic             neg_a;
    logic             neg_b;
  } pgg_work_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } pgg_result_t;
endpackage
`default_nettype wire

### rtl/pgg_fifo.sv
`default_nettype none
module pgg_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         push,
  input  wire logic [WIDTH-1:0]             din,
  input  wire logic                         pop,
  output logic      [WIDTH-1:0]             dout,
  output logic                              full,
  output logic                              empty,
  output logic      [$clog2(DEPTH+1)-1:0]   level
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0] wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [LW-1:0] cnt_r, cnt_nxt;
  logic do_push, do_pop;

  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign full  = (cnt_r == LW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign level = cnt_r;
  assign dout  = mem[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + PW'(1);
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + LW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - LW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end
endmodule
`default_nettype wire

### rtl/pgg_front.sv
`default_nettype none
module pgg_front #(
  parameter int UNIFORM_BITS = pgg_pkg::UNIFORM_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_push,
  output logic                               in_full,
  input  wire logic [pgg_pkg::IN_W-1:0]      in_uniform_a,
  input  wire logic [pgg_pkg::IN_W-1:0]      in_uniform_b,
  input  wire logic [pgg_pkg::WQ_LVL_W-1:0]  wq_level,
  output logic                               wq_push,
  output pgg_pkg::pgg_work_t                 wq_data
);
  import pgg_pkg::*;
  localparam int B = UNIFORM_BITS;
  localparam int SW = 2 * B + 1;

  logic [31:0] ua_ext, ub_ext;
  logic [B:0] maxv, twice_a, twice_b, ma_full, mb_full;
  logic na, nb, acc;
  logic v0_r, v1_r;
  logic [B-1:0] ma0_r, mb0_r, ma1_r, mb1_r;
  logic na0_r, nb0_r, na1_r, nb1_r;
  logic [2*B-1:0] sa1_r, sb1_r;
  logic [SW-1:0] sum;
  logic [62:0] sh63;
  logic [WQ_LVL_W+1:0] inflight;

  assign inflight = (WQ_LVL_W+2)'(wq_level) + (WQ_LVL_W+2)'(v0_r) + (WQ_LVL_W+2)'(v1_r);
  assign in_full = (inflight >= (WQ_LVL_W+2)'(WQ_DEPTH));
  assign acc = in_push && !in_full;

  assign ua_ext  = 32'(in_uniform_a);
  assign ub_ext  = 32'(in_uniform_b);
  assign maxv    = {1'b0, {B{1'b1}}};
  assign twice_a = {ua_ext[B-1:0], 1'b0};
  assign twice_b = {ub_ext[B-1:0], 1'b0};
  assign na = (twice_a < maxv);
  assign nb = (twice_b < maxv);
  assign ma_full = na ? (maxv - twice_a) : (twice_a - maxv);
  assign mb_full = nb ? (maxv - twice_b) : (twice_b - maxv);

  assign sum = {1'b0, sa1_r} + {1'b0, sb1_r};

  generate
    if (2 * B > 62) begin : g_shr
      assign sh63 = 63'(sum >> (2 * B - 62));
    end else begin : g_shl
      assign sh63 = 63'(sum) << (62 - 2 * B);
    end
  endgenerate

  assign wq_push = v1_r && (sum != '0) && !sh63[62];
  always_comb begin
    wq_data.sq    = (sh63[61:0] == '0) ? 62'd1 : sh63[61:0];
    wq_data.mag_a = MAG_W'(ma1_r);
    wq_data.mag_b = MAG_W'(mb1_r);
    wq_data.neg_a = na1_r;
    wq_data.neg_b = nb1_r;
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      ma0_r <= ma_full[B-1:0];
      mb0_r <= mb_full[B-1:0];
      na0_r <= na;
      nb0_r <= nb;
    end
    if (v0_r) begin
      ma1_r <= ma0_r;
      mb1_r <= mb0_r;
      na1_r <= na0_r;
      nb1_r <= nb0_r;
      sa1_r <= ma0_r * ma0_r;
      sb1_r <= mb0_r * mb0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else begin
      v0_r <= acc;
      v1_r <= v0_r;
    end
  end
endmodule
`default_nettype wire

### rtl/pgg_back.sv
`default_nettype none
module pgg_back #(
  parameter int UNIFORM_BITS = pgg_pkg::UNIFORM_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 wq_empty,
  input  wire pgg_pkg::pgg_work_t   wq_data,
  output logic                      wq_pop,
  input  wire logic                 rq_full,
  output logic                      rq_push,
  output pgg_pkg::pgg_result_t      rq_data
);
  import pgg_pkg::*;
  localparam int B = UNIFORM_BITS;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_NORM   = 4'd1;
  localparam logic [3:0] S_LOG    = 4'd2;
  localparam logic [3:0] S_MUL    = 4'd3;
  localparam logic [3:0] S_SQRT_R = 4'd4;
  localparam logic [3:0] S_SQRT_H = 4'd5;
  localparam logic [3:0] S_SCALE  = 4'd6;
  localparam logic [3:0] S_CHK    = 4'd7;
  localparam logic [3:0] S_DIV    = 4'd8;
  localparam logic [3:0] S_EMIT   = 4'd9;

  logic [3:0] st_r, st_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic lane_r, lane_nxt;
  pgg_work_t work_r;
  logic [SQ_W-1:0] x_r;
  logic [5:0] z_r;
  logic [30:0] m_r;
  logic [LOG_FRAC_W-1:0] frac_r;
  logic [63:0] rem_r, res_r, bit_r;
  logic [19:0] r_r;
  logic [30:0] h_r;
  logic [51:0] num_r, dsh_r;
  logic [16:0] quo_r;
  logic sat_r;

  logic [5:0] k;
  logic [SQ_W-1:0] xsh;
  logic [61:0] msq;
  logic [31:0] mn;
  logic [29:0] g;
  logic [60:0] tprod;
  logic [63:0] trial, rem_n, res_n;
  logic [B-1:0] magb;
  logic [30:0] v31;
  logic [50:0] prod;
  logic neg;
  logic [16:0] qc;
  logic do_sub;

  assign k = 6'd32 >> cnt_r[2:0];
  assign xsh = x_r << k;
  assign msq = m_r * m_r;
  assign mn = msq[61:30];
  assign g = {z_r + 6'd1, 24'd0} - 30'(frac_r);
  assign tprod = g * TWO_LN2_Q30;

  assign trial = res_r + bit_r;
  always_comb begin
    if (rem_r >= trial) begin
      rem_n = rem_r - trial;
      res_n = (res_r >> 1) + bit_r;
    end else begin
      rem_n = rem_r;
      res_n = res_r >> 1;
    end
  end

  assign magb = lane_r ? work_r.mag_b[B-1:0] : work_r.mag_a[B-1:0];
  assign neg  = lane_r ? work_r.neg_b : work_r.neg_a;
  generate
    if (B <= 31) begin : g_vl
      assign v31 = 31'(magb) << (31 - B);
    end else begin : g_vr
      assign v31 = magb[B-1:1];
    end
  endgenerate
  assign prod = v31 * r_r;
  assign do_sub = (num_r >= dsh_r);

  always_comb begin
    if (neg) begin
      qc = (sat_r || quo_r > 17'd32768) ? 17'd32768 : quo_r;
      rq_data.sample = SAMPLE_W'(17'h10000 - qc);
    end else begin
      qc = (sat_r || quo_r > 17'd32767) ? 17'd32767 : quo_r;
      rq_data.sample = qc[15:0];
    end
    rq_data.last = lane_r;
  end

  assign wq_pop  = (st_r == S_IDLE) && !wq_empty;
  assign rq_push = (st_r == S_EMIT) && !rq_full;

  always_comb begin
    st_nxt   = st_r;
    cnt_nxt  = cnt_r;
    lane_nxt = lane_r;
    unique case (st_r)
      S_IDLE: begin
        if (!wq_empty) begin
          st_nxt  = S_NORM;
          cnt_nxt = '0;
          lane_nxt = 1'b0;
        end
      end
      S_NORM: begin
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd5) begin
          st_nxt  = S_LOG;
          cnt_nxt = '0;
        end
      end
      S_LOG: begin
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'(LOG_FRAC_W - 1)) begin
          st_nxt = S_MUL;
        end
      end
      S_MUL: begin
        st_nxt = S_SQRT_R;
      end
      S_SQRT_R: begin
        if (bit_r[0]) begin
          st_nxt = S_SQRT_H;
        end
      end
      S_SQRT_H: begin
        if (bit_r[0]) begin
          st_nxt = S_SCALE;
        end
      end
      S_SCALE: begin
        st_nxt = S_CHK;
      end
      S_CHK: begin
        st_nxt  = S_DIV;
        cnt_nxt = '0;
      end
      S_DIV: begin
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd16) begin
          st_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!rq_full) begin
          if (lane_r) begin
            st_nxt = S_IDLE;
          end else begin
            st_nxt   = S_SCALE;
            lane_nxt = 1'b1;
          end
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      S_IDLE: begin
        work_r <= wq_data;
        x_r    <= wq_data.sq;
        z_r    <= '0;
      end
      S_NORM: begin
        if ((x_r >> (6'd62 - k)) == '0) begin
          x_r <= xsh;
          z_r <= z_r + k;
        end
        m_r    <= (x_r >> (6'd62 - k)) == '0 ? xsh[61:31] : x_r[61:31];
        frac_r <= '0;
      end
      S_LOG: begin
        frac_r <= {frac_r[LOG_FRAC_W-2:0], mn[31]};
        m_r    <= mn[31] ? mn[31:1] : mn[30:0];
      end
      S_MUL: begin
        rem_r <= 64'(tprod[60:30]) << 8;
        res_r <= '0;
        bit_r <= 64'd1 << 62;
      end
      S_SQRT_R: begin
        if (bit_r[0]) begin
          r_r   <= res_n[19:0];
          rem_r <= 64'(work_r.sq);
          res_r <= '0;
          bit_r <= 64'd1 << 62;
        end else begin
          rem_r <= rem_n;
          res_r <= res_n;
          bit_r <= bit_r >> 2;
        end
      end
      S_SQRT_H: begin
        rem_r <= rem_n;
        res_r <= res_n;
        bit_r <= bit_r >> 2;
        if (bit_r[0]) begin
          h_r <= res_n[30:0];
        end
      end
      S_SCALE: begin
        num_r <= 52'(prod) + 52'({h_r, 3'b000});
        dsh_r <= 52'({h_r, 4'b0000}) << 16;
        quo_r <= '0;
      end
      S_CHK: begin
        sat_r <= (53'(num_r) >= {dsh_r, 1'b0});
      end
      S_DIV: begin
        if (do_sub) begin
          num_r <= num_r - dsh_r;
        end
        quo_r <= {quo_r[15:0], do_sub};
        dsh_r <= dsh_r >> 1;
      end
      S_EMIT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      cnt_r  <= '0;
      lane_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      cnt_r  <= cnt_nxt;
      lane_r <= lane_nxt;
    end
  end
endmodule
`default_nettype wire

### rtl/polar_gaussian_generator_core.sv
// back end: works on one pair at a time and takes the next only when idle (log2 squaring loop,
//   two 32-step square roots, two 17-step divisions); front takes an item per cycle
//   until its 4-entry work queue, counting pairs still in flight, fills
// reset: synchronous active-low rst_n empties both queues and idles the back end
`default_nettype none
module polar_gaussian_generator_core #(
  parameter int UNIFORM_BITS = pgg_pkg::UNIFORM_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_push,
  output logic                                   in_full,
  input  wire logic [pgg_pkg::IN_W-1:0]          in_uniform_a,
  input  wire logic [pgg_pkg::IN_W-1:0]          in_uniform_b,
  output logic                                   out_empty,
  input  wire logic                              out_pop,
  output logic signed [pgg_pkg::SAMPLE_W-1:0]    out_sample,
  output logic                                   out_last
);
  import pgg_pkg::*;

  logic wq_push, wq_pop, wq_full, wq_empty;
  pgg_work_t wq_din, wq_dout;
  logic [WQ_LVL_W-1:0] wq_level;
  logic rq_push, rq_full;
  pgg_result_t rq_din, rq_dout;
  logic [$clog2(RQ_DEPTH+1)-1:0] rq_level;

  pgg_front #(.UNIFORM_BITS(UNIFORM_BITS)) u_front (
    .clk, .rst_n, .in_push, .in_full, .in_uniform_a, .in_uniform_b,
    .wq_level, .wq_push, .wq_data(wq_din)
  );

  pgg_fifo #(.WIDTH($bits(pgg_work_t)), .DEPTH(WQ_DEPTH)) u_wq (
    .clk, .rst_n, .push(wq_push), .din(wq_din), .pop(wq_pop), .dout(wq_dout),
    .full(wq_full), .empty(wq_empty), .level(wq_level)
  );

  pgg_back #(.UNIFORM_BITS(UNIFORM_BITS)) u_back (
    .clk, .rst_n, .wq_empty, .wq_data(wq_dout), .wq_pop,
    .rq_full, .rq_push, .rq_data(rq_din)
  );

  pgg_fifo #(.WIDTH($bits(pgg_result_t)), .DEPTH(RQ_DEPTH)) u_rq (
    .clk, .rst_n, .push(rq_push), .din(rq_din), .pop(out_pop), .dout(rq_dout),
    .full(rq_full), .empty(out_empty), .level(rq_level)
  );

  assign out_sample = rq_dout.sample;
  assign out_last   = rq_dout.last;

  a_wq_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    wq_push |-> !wq_full) else $error("work queue overflow");
  a_rq_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    rq_push |-> !rq_full) else $error("result queue overflow");
  a_rq_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_empty == (rq_level == '0)) else $error("result level mismatch");
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> out_empty) else $error("not empty after reset");
endmodule
`default_nettype wire
